### hw/rtl/dkp_pkg.sv
package dkp_pkg;

    localparam int KEY_COUNT_DEF   = 8;
    localparam int KEY_W           = 4;
    localparam int TIME_W          = 32;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_ADDR_W      = 3;

    localparam logic [TIME_W-1:0] DEBOUNCE_RESET   = TIME_W'(20);
    localparam logic [TIME_W-1:0] LONG_PRESS_RESET = TIME_W'(800);

    // Register select codes (word address bit of the configuration port).
    localparam logic REG_DEBOUNCE   = 1'b0;
    localparam logic REG_LONG_PRESS = 1'b1;

    typedef enum logic [1:0] {
        OUT_NOTHING    = 2'd0,
        OUT_IGNORED    = 2'd1,
        OUT_CLASSIFIED = 2'd2
    } t_outcome;

    typedef struct packed {
        logic              in_range;
        logic [KEY_W-1:0]  key;
        logic              level;
        logic [TIME_W-1:0] elapsed;
    } t_item;

    typedef struct packed {
        t_outcome         outcome;
        logic [KEY_W-1:0] key;
        logic             is_long;
        logic             held_now;
    } t_result;

    typedef struct packed {
        logic [TIME_W-1:0] debounce_ms;
        logic [TIME_W-1:0] long_press_ms;
    } t_cfg;

    // Unsigned add that sticks at all ones instead of wrapping.
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

endpackage

### hw/rtl/dkp_fifo.sv
module dkp_fifo import dkp_pkg::*; #(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/dkp_cfg.sv
module dkp_cfg import dkp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= DEBOUNCE_RESET;
            r_cfg.long_press_ms <= LONG_PRESS_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_DEBOUNCE:   r_cfg.debounce_ms   <= pwdata;
                REG_LONG_PRESS: r_cfg.long_press_ms <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DEBOUNCE:   prdata = r_cfg.debounce_ms;
            REG_LONG_PRESS: prdata = r_cfg.long_press_ms;
            default:        prdata = '0;
        endcase
    end

endmodule

### hw/rtl/dkp_front.sv
module dkp_front import dkp_pkg::*; #(
    parameter int KEY_COUNT   = KEY_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [KEY_W-1:0]  i_key_index,
    input  logic              i_level_pressed,
    input  logic [TIME_W-1:0] i_elapsed_ms,
    input  logic              i_take,
    output t_item             o_item,
    output logic              o_valid
);

    t_item            item_in;
    logic [$bits(t_item)-1:0] q_data;
    logic             q_empty;

    // Range check is done here so the back end sees a ready-made flag.
    always_comb begin
        item_in.in_range = ({1'b0, i_key_index} < (KEY_W + 1)'(KEY_COUNT));
        item_in.key      = i_key_index;
        item_in.level    = i_level_pressed;
        item_in.elapsed  = i_elapsed_ms;
    end

    dkp_fifo #(
        .W     ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (item_in),
        .o_full  (full),
        .i_pop   (i_take),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign o_item  = t_item'(q_data);
    assign o_valid = !q_empty;

endmodule

### hw/rtl/dkp_back.sv
module dkp_back import dkp_pkg::*; #(
    parameter int KEY_COUNT   = KEY_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_item            i_item,
    input  logic             i_valid,
    output logic             o_take,
    input  logic             pop,
    output logic             empty,
    output logic [1:0]       o_outcome,
    output logic [KEY_W-1:0] o_pressed_key,
    output logic             o_is_long,
    output logic             o_held_now
);

    localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    logic [KEY_COUNT-1:0] r_held, r_raw, r_long_sent, r_chord;
    logic [TIME_W-1:0]    r_hold   [KEY_COUNT];
    logic [TIME_W-1:0]    r_settle [KEY_COUNT];

    logic [IDX_W-1:0]  idx;
    logic              res_full, step, upd;
    logic              cur_held, cur_raw, cur_long, cur_chord, other_held;
    logic [TIME_W-1:0] hold_sum, settle_base, settle_sum;
    logic              n_held, n_raw, n_long, n_chord, mark_all;
    logic [TIME_W-1:0] n_hold, n_settle;
    t_result           res;
    logic [$bits(t_result)-1:0] res_q;
    t_result           res_out;

    assign idx    = i_item.key[IDX_W-1:0];
    assign step   = i_valid && !res_full;
    assign o_take = step;
    assign upd    = step && i_item.in_range;

    always_comb begin
        cur_held    = r_held[idx];
        cur_raw     = r_raw[idx];
        cur_long    = r_long_sent[idx];
        cur_chord   = r_chord[idx];
        other_held  = |(r_held & ~(KEY_COUNT'(1) << idx));
        hold_sum    = sat_add(r_hold[idx], i_item.elapsed);
        // A raw level that changed during settling restarts the settle timer.
        settle_base = (i_item.level != cur_raw) ? '0 : r_settle[idx];
        settle_sum  = sat_add(settle_base, i_item.elapsed);

        n_held   = cur_held;
        n_raw    = i_item.level;
        n_hold   = r_hold[idx];
        n_settle = '0;
        n_long   = cur_long;
        n_chord  = cur_chord;
        mark_all = 1'b0;

        res.outcome  = OUT_NOTHING;
        res.key      = '0;
        res.is_long  = 1'b0;

        if (i_item.level == cur_held) begin
            if (cur_held) begin
                n_hold = hold_sum;
                if (hold_sum >= i_cfg.long_press_ms && !cur_long && !cur_chord) begin
                    n_long      = 1'b1;
                    res.outcome = OUT_CLASSIFIED;
                    res.key     = i_item.key;
                    res.is_long = 1'b1;
                end
            end
        end else begin
            n_settle = settle_sum;
            if (settle_sum >= i_cfg.debounce_ms) begin
                n_settle = '0;
                n_hold   = '0;
                n_long   = 1'b0;
                n_held   = i_item.level;
                if (i_item.level) begin
                    n_chord  = other_held;
                    mark_all = other_held;
                end else begin
                    n_chord = 1'b0;
                    if (cur_chord) begin
                        res.outcome = OUT_IGNORED;
                    end else if (!cur_long) begin
                        res.outcome = OUT_CLASSIFIED;
                        res.key     = i_item.key;
                    end
                end
            end
        end
        res.held_now = n_held;

        if (!i_item.in_range) begin
            res.outcome  = OUT_IGNORED;
            res.key      = '0;
            res.is_long  = 1'b0;
            res.held_now = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_raw       <= '0;
            r_long_sent <= '0;
            r_chord     <= '0;
            for (int i = 0; i < KEY_COUNT; i++) begin
                r_hold[i]   <= '0;
                r_settle[i] <= '0;
            end
        end else if (upd) begin
            for (int i = 0; i < KEY_COUNT; i++) begin
                if (IDX_W'(i) == idx) begin
                    r_held[i]      <= n_held;
                    r_raw[i]       <= n_raw;
                    r_long_sent[i] <= n_long;
                    r_chord[i]     <= n_chord;
                    r_hold[i]      <= n_hold;
                    r_settle[i]    <= n_settle;
                end else if (mark_all && r_held[i]) begin
                    r_chord[i] <= 1'b1;
                end
            end
        end
    end

    dkp_fifo #(
        .W     ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign res_out       = t_result'(res_q);
    assign o_outcome     = res_out.outcome;
    assign o_pressed_key = res_out.key;
    assign o_is_long     = res_out.is_long;
    assign o_held_now    = res_out.held_now;

`ifndef SYNTH
    a_range_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && !i_item.in_range |-> res.outcome == OUT_IGNORED && !res.held_now)
        else $error("out-of-range key not reported as ignored");

    a_long_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd && res.is_long |-> cur_held && !cur_long && !cur_chord)
        else $error("long press reported for a key not eligible");

    a_press_sets_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd && !cur_held && n_held |=> r_held[$past(idx)])
        else $error("accepted press did not set the held state");

    a_step_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> !res_full && i_valid)
        else $error("item taken without room for its result");
`endif

endmodule

### hw/rtl/debounced_key_press_classifier.sv
// An item accepted into the input queue is classified by the back end as it is taken,
// and its result is registered in the result queue, from which it is then popped.
// Throughput: one item per cycle while the result queue has room; each item updates
// its key's state as it is taken; the input and result queues hold QUEUE_DEPTH (2) entries.
// Reset: synchronous, active low; clears both queues and all key state, and sets
// the debounce and long-press registers to 20 and 800 ms.
module debounced_key_press_classifier import dkp_pkg::*; #(
    parameter int KEY_COUNT   = KEY_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [KEY_W-1:0]      i_key_index,
    input  logic                  i_level_pressed,
    input  logic [TIME_W-1:0]     i_elapsed_ms,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            o_outcome,
    output logic [KEY_W-1:0]      o_pressed_key,
    output logic                  o_is_long,
    output logic                  o_held_now,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg  cfg;
    t_item item;
    logic  item_valid, item_take;

    dkp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dkp_front #(
        .KEY_COUNT   (KEY_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_key_index     (i_key_index),
        .i_level_pressed (i_level_pressed),
        .i_elapsed_ms    (i_elapsed_ms),
        .i_take          (item_take),
        .o_item          (item),
        .o_valid         (item_valid)
    );

    dkp_back #(
        .KEY_COUNT   (KEY_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_item        (item),
        .i_valid       (item_valid),
        .o_take        (item_take),
        .pop           (pop),
        .empty         (empty),
        .o_outcome     (o_outcome),
        .o_pressed_key (o_pressed_key),
        .o_is_long     (o_is_long),
        .o_held_now    (o_held_now)
    );

endmodule
